/* hdl/ecm_pkg.sv */
// shared types, codes and crc helper for the frame modem
`timescale 1ns / 1ps
package ecm_pkg;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data_in;
  } item_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       rd_valid;
    logic [7:0] rd_byte;
    logic       rd_last;
    logic       frame_ready;
    logic       tx_failed;
    logic       rx_indicator;
    logic [2:0] state_code;
  } result_t;

  typedef enum logic [1:0] {
    OP_LINE    = 2'd0,
    OP_TX_DONE = 2'd1,
    OP_LOAD    = 2'd2,
    OP_READ    = 2'd3
  } op_kind_t;

  typedef enum logic [2:0] {
    MD_IDLE   = 3'd0,
    MD_RX_HDR = 3'd1,
    MD_RX_PAY = 3'd2,
    MD_RX_CRC = 3'd3,
    MD_TX_HDR = 3'd4,
    MD_TX_PAY = 3'd5,
    MD_TX_CRC = 3'd6
  } mode_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_EXEC = 2'd1,
    BK_READ = 2'd2
  } back_state_t;

  typedef struct packed {
    logic [7:0] header_first;
    logic [7:0] header_second;
  } cfg_t;

  // classified command as it travels from front to back
  typedef struct packed {
    op_kind_t   kind;
    logic [7:0] data;
    logic       hdr_first_hit;
    logic       hdr_second_hit;
  } cmd_t;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SECOND = 2'd1;

  localparam logic [7:0] HEADER_FIRST_RESET  = 8'd170;
  localparam logic [7:0] HEADER_SECOND_RESET = 8'd254;

  localparam logic [7:0] CRC8_POLY = 8'h8C;

  localparam int QUEUE_DEPTH = 2;

  // one byte of reflected crc-8, eight shift steps
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] d);
    logic [7:0] c;
    c = crc ^ d;
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ CRC8_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

/* hdl/ecm_front.sv */
// front end: config registers, item intake and header classification
`timescale 1ns / 1ps
module ecm_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  ecm_pkg::item_t                item,
  input  logic                          cfg_we,
  input  logic [ecm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data,
  input  logic                          q_full,
  output logic                          push,
  output ecm_pkg::cmd_t                 cmd,
  output ecm_pkg::cfg_t                 cfg
);
  import ecm_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_first  <= HEADER_FIRST_RESET;
      cfg.header_second <= HEADER_SECOND_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HEADER_FIRST:  cfg.header_first  <= cfg_data;
        CFG_HEADER_SECOND: cfg.header_second <= cfg_data;
        default: ;
      endcase
    end
  end

  assign push = start && !q_full;

  always_comb begin
    cmd.kind           = op_kind_t'(item.op);
    cmd.data           = item.data_in;
    cmd.hdr_first_hit  = (item.data_in == cfg.header_first);
    cmd.hdr_second_hit = (item.data_in == cfg.header_second);
  end

endmodule

/* hdl/ecm_queue.sv */
// short command queue between front and back
`timescale 1ns / 1ps
module ecm_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ecm_pkg::cmd_t wr_cmd,
  input  logic          pop,
  output ecm_pkg::cmd_t rd_cmd,
  output logic          empty,
  output logic          full
);
  import ecm_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

  cmd_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign empty   = (count == '0);
  assign full    = (count == CNT_W'(QUEUE_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_cmd  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wr_cmd;
    end
  end

endmodule

/* hdl/ecm_back.sv */
// back end: modem state, frame and send stores, result register
`timescale 1ns / 1ps
module ecm_back #(
  parameter int PAYLOAD_BYTES = 16,
  parameter int RX_FRAMES     = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  ecm_pkg::cmd_t    cmd,
  input  logic             q_empty,
  output logic             q_pop,
  input  ecm_pkg::cfg_t    cfg,
  output logic             res_valid,
  output ecm_pkg::result_t res
);
  import ecm_pkg::*;

  localparam int CNT_W    = $clog2(PAYLOAD_BYTES + 1);
  localparam int SA_W     = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
  localparam int SL_W     = $clog2(RX_FRAMES);
  localparam int FS_DEPTH = RX_FRAMES * PAYLOAD_BYTES;
  localparam int FA_W     = $clog2(FS_DEPTH);
  localparam logic [CNT_W-1:0] PAY_CNT   = CNT_W'(PAYLOAD_BYTES);
  localparam logic [CNT_W-1:0] LAST_IDX  = CNT_W'(PAYLOAD_BYTES - 1);
  localparam logic [SL_W-1:0]  LAST_SLOT = SL_W'(RX_FRAMES - 1);
  localparam logic [FA_W-1:0]  SLOT_LEN  = FA_W'(PAYLOAD_BYTES);
  localparam logic             MULTI     = (PAYLOAD_BYTES > 1);

  back_state_t bk_state, bk_state_next;
  cmd_t        cur, cur_next;
  mode_t       mode, mode_next;
  logic [SL_W-1:0]  active_slot, active_slot_next;
  logic [SL_W-1:0]  oldest_slot, oldest_slot_next;
  logic [CNT_W-1:0] rx_index, rx_index_next;
  logic [7:0]       rx_crc, rx_crc_next;
  logic [CNT_W-1:0] tx_index, tx_index_next;
  logic [CNT_W-1:0] load_index, load_index_next;
  logic [7:0]       send_crc, send_crc_next;
  logic             fail_flag, fail_flag_next;
  logic [7:0]       last_sent, last_sent_next;
  logic             echo_seen, echo_seen_next;
  logic             indicator, indicator_next;
  logic [CNT_W-1:0] rd_cnt, rd_cnt_next;
  logic [FA_W-1:0]  rd_ptr, rd_ptr_next;
  logic             res_valid_next;
  result_t          res_next;

  logic [7:0]      frame_mem [FS_DEPTH];
  logic [7:0]      fs_q;
  logic            fs_we, fs_re;
  logic [FA_W-1:0] fs_waddr, fs_raddr;
  logic [7:0]      send_mem [PAYLOAD_BYTES];
  logic [7:0]      ss_q;
  logic            ss_we, ss_re;
  logic [SA_W-1:0] ss_waddr, ss_raddr;

  logic            frame_ready_now;
  logic            read_hit;
  logic            emit_en;
  logic [7:0]      emit_v;
  logic [CNT_W-1:0] rx_inc, tx_inc, load_inc;
  logic [FA_W-1:0] oldest_base, active_base;
  logic [7:0]      load_crc_in;

  assign frame_ready_now = (oldest_slot != active_slot);
  assign read_hit        = (cur.kind == OP_READ) && frame_ready_now;
  assign rx_inc          = rx_index + CNT_W'(1);
  assign tx_inc          = tx_index + CNT_W'(1);
  assign load_inc        = load_index + CNT_W'(1);
  assign oldest_base     = FA_W'(oldest_slot) * SLOT_LEN;
  assign active_base     = FA_W'(active_slot) * SLOT_LEN;
  assign load_crc_in     = (load_index == '0) ? 8'h00 : send_crc;

  always_comb begin
    bk_state_next = bk_state;
    case (bk_state)
      BK_IDLE: if (!q_empty) bk_state_next = BK_EXEC;
      BK_EXEC: bk_state_next = (read_hit && MULTI) ? BK_READ : BK_IDLE;
      BK_READ: if (rd_cnt == LAST_IDX) bk_state_next = BK_IDLE;
      default: bk_state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    cur_next         = cur;
    mode_next        = mode;
    active_slot_next = active_slot;
    oldest_slot_next = oldest_slot;
    rx_index_next    = rx_index;
    rx_crc_next      = rx_crc;
    tx_index_next    = tx_index;
    load_index_next  = load_index;
    send_crc_next    = send_crc;
    fail_flag_next   = fail_flag;
    last_sent_next   = last_sent;
    echo_seen_next   = echo_seen;
    indicator_next   = indicator;
    rd_cnt_next      = rd_cnt;
    rd_ptr_next      = rd_ptr;
    res_valid_next   = 1'b0;
    res_next         = res;
    q_pop            = 1'b0;
    fs_we            = 1'b0;
    fs_waddr         = active_base + FA_W'(rx_index[SA_W-1:0]);
    fs_re            = 1'b0;
    fs_raddr         = oldest_base;
    ss_we            = 1'b0;
    ss_waddr         = load_index[SA_W-1:0];
    ss_re            = 1'b0;
    ss_raddr         = tx_index[SA_W-1:0];
    emit_en          = 1'b0;
    emit_v           = 8'h00;

    case (bk_state)
      BK_IDLE: begin
        if (!q_empty) begin
          // fetch the store words this item may need
          q_pop    = 1'b1;
          cur_next = cmd;
          ss_re    = (tx_index < PAY_CNT);
          fs_re    = 1'b1;
        end
      end

      BK_EXEC: begin
        case (cur.kind)
          OP_LINE: begin
            case (mode)
              MD_IDLE: begin
                if (cur.hdr_first_hit) begin
                  mode_next      = MD_RX_HDR;
                  indicator_next = 1'b1;
                end
              end
              MD_RX_HDR: begin
                if (cur.hdr_second_hit) begin
                  mode_next     = MD_RX_PAY;
                  rx_index_next = '0;
                  rx_crc_next   = 8'h00;
                end else begin
                  mode_next = MD_IDLE;
                end
              end
              MD_RX_PAY: begin
                fs_we         = 1'b1;
                rx_crc_next   = crc8_byte(rx_crc, cur.data);
                rx_index_next = rx_inc;
                if (rx_inc >= PAY_CNT) mode_next = MD_RX_CRC;
              end
              MD_RX_CRC: begin
                if (cur.data == rx_crc) begin
                  active_slot_next = (active_slot == LAST_SLOT) ? '0 : active_slot + SL_W'(1);
                end
                indicator_next = 1'b0;
                mode_next      = MD_IDLE;
              end
              default: begin
                // echo check while sending
                if (cur.data != last_sent) begin
                  mode_next      = MD_IDLE;
                  fail_flag_next = 1'b1;
                end else begin
                  echo_seen_next = 1'b1;
                end
              end
            endcase
          end

          OP_TX_DONE: begin
            if (echo_seen) begin
              case (mode)
                MD_TX_HDR: begin
                  emit_en       = 1'b1;
                  emit_v        = cfg.header_second;
                  mode_next     = MD_TX_PAY;
                  tx_index_next = '0;
                end
                MD_TX_PAY: begin
                  emit_en       = 1'b1;
                  emit_v        = (tx_index < PAY_CNT) ? ss_q : 8'h00;
                  tx_index_next = tx_inc;
                  if (tx_inc >= PAY_CNT) mode_next = MD_TX_CRC;
                end
                MD_TX_CRC: begin
                  emit_en   = 1'b1;
                  emit_v    = send_crc;
                  mode_next = MD_IDLE;
                end
                default: ;
              endcase
            end else begin
              fail_flag_next = 1'b1;
              mode_next      = MD_IDLE;
            end
          end

          OP_LOAD: begin
            if (mode != MD_IDLE) begin
              fail_flag_next  = 1'b1;
              load_index_next = '0;
            end else begin
              ss_we           = 1'b1;
              send_crc_next   = crc8_byte(load_crc_in, cur.data);
              load_index_next = load_inc;
              if (load_inc >= PAY_CNT) begin
                load_index_next = '0;
                tx_index_next   = '0;
                mode_next       = MD_TX_HDR;
                fail_flag_next  = 1'b0;
                emit_en         = 1'b1;
                emit_v          = cfg.header_first;
              end
            end
          end

          OP_READ: begin
            if (frame_ready_now) begin
              oldest_slot_next = (oldest_slot == LAST_SLOT) ? '0 : oldest_slot + SL_W'(1);
              rd_cnt_next      = CNT_W'(1);
              fs_re            = MULTI;
              fs_raddr         = oldest_base + FA_W'(1);
              rd_ptr_next      = oldest_base + FA_W'(2);
            end
          end

          default: ;
        endcase

        if (emit_en) begin
          echo_seen_next = 1'b0;
          last_sent_next = emit_v;
        end

        res_valid_next        = 1'b1;
        res_next.tx_valid     = emit_en;
        res_next.tx_byte      = emit_v;
        res_next.rd_valid     = read_hit;
        res_next.rd_byte      = read_hit ? fs_q : 8'h00;
        res_next.rd_last      = !read_hit || !MULTI;
        res_next.frame_ready  = (oldest_slot_next != active_slot_next);
        res_next.tx_failed    = fail_flag_next;
        res_next.rx_indicator = indicator_next;
        res_next.state_code   = mode_next;
      end

      BK_READ: begin
        if (rd_cnt != LAST_IDX) begin
          fs_re       = 1'b1;
          fs_raddr    = rd_ptr;
          rd_ptr_next = rd_ptr + FA_W'(1);
          rd_cnt_next = rd_cnt + CNT_W'(1);
        end
        res_valid_next        = 1'b1;
        res_next.tx_valid     = 1'b0;
        res_next.tx_byte      = 8'h00;
        res_next.rd_valid     = 1'b1;
        res_next.rd_byte      = fs_q;
        res_next.rd_last      = (rd_cnt == LAST_IDX);
        res_next.frame_ready  = frame_ready_now;
        res_next.tx_failed    = fail_flag;
        res_next.rx_indicator = indicator;
        res_next.state_code   = mode;
      end

      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bk_state    <= BK_IDLE;
      mode        <= MD_IDLE;
      active_slot <= '0;
      oldest_slot <= '0;
      rx_index    <= '0;
      rx_crc      <= 8'h00;
      tx_index    <= '0;
      load_index  <= '0;
      send_crc    <= 8'h00;
      fail_flag   <= 1'b0;
      last_sent   <= 8'h00;
      echo_seen   <= 1'b0;
      indicator   <= 1'b1;
      rd_cnt      <= '0;
      rd_ptr      <= '0;
      res_valid   <= 1'b0;
    end else begin
      bk_state    <= bk_state_next;
      mode        <= mode_next;
      active_slot <= active_slot_next;
      oldest_slot <= oldest_slot_next;
      rx_index    <= rx_index_next;
      rx_crc      <= rx_crc_next;
      tx_index    <= tx_index_next;
      load_index  <= load_index_next;
      send_crc    <= send_crc_next;
      fail_flag   <= fail_flag_next;
      last_sent   <= last_sent_next;
      echo_seen   <= echo_seen_next;
      indicator   <= indicator_next;
      rd_cnt      <= rd_cnt_next;
      rd_ptr      <= rd_ptr_next;
      res_valid   <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cur <= cur_next;
    res <= res_next;
  end

  always_ff @(posedge clk) begin
    if (fs_we) frame_mem[fs_waddr] <= cur.data;
    if (fs_re) fs_q <= frame_mem[fs_raddr];
  end

  always_ff @(posedge clk) begin
    if (ss_we) send_mem[ss_waddr] <= cur.data;
    if (ss_re) ss_q <= send_mem[ss_raddr];
  end

endmodule

/* hdl/echo_checked_crc8_frame_modem_core.sv */
// top level of the echo checked crc-8 frame modem
`timescale 1ns / 1ps
// usage
// - input channel: an item (op, data_in) is taken at a rising edge with start high and
//   busy low; busy rises only while the two-entry command queue is full
// - config port: cfg_we with cfg_index 0 (header_first) or 1 (header_second) and cfg_data
//   writes a header byte at once; other indexes are ignored; write only while idle
// - result channel: res_valid is high for one cycle per result item and res carries it;
//   the receiver cannot stall, so each result is taken in the cycle it shows
// - timing: with the back end free, a taken item goes into the queue, is popped with its
//   store fetch, is executed, and its first result comes from the result register
// - the back end handles an item in two steps (store fetch, then execute) and pops the
//   following item only after that; a read of a ready frame streams PAYLOAD_BYTES results
//   on back to back cycles and holds the back end until the last one
// - the queue lets the front keep taking items while the back end streams a frame
// - reset (rst, synchronous) empties the queue, returns the modem to idle with the
//   indicator high and restores both header bytes; the stores are not cleared and
//   no clearing pass runs, so items are taken from the first cycle after reset
module echo_checked_crc8_frame_modem_core #(
  parameter int PAYLOAD_BYTES = 16,
  parameter int RX_FRAMES     = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  ecm_pkg::item_t                item,
  input  logic                          cfg_we,
  input  logic [ecm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data,
  output logic                          res_valid,
  output ecm_pkg::result_t              res
);
  import ecm_pkg::*;

  // front to queue
  logic push;
  cmd_t front_cmd;
  cfg_t cfg;

  // queue to back
  logic q_full;
  logic q_empty;
  logic q_pop;
  cmd_t q_cmd;

  // intake, header match against the live config
  ecm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .item      (item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .push      (push),
    .cmd       (front_cmd),
    .cfg       (cfg)
  );

  // decouples intake from execution
  ecm_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_cmd (front_cmd),
    .pop    (q_pop),
    .rd_cmd (q_cmd),
    .empty  (q_empty),
    .full   (q_full)
  );

  // busy is the queue being full
  assign busy = q_full;

  // modem state machine, frame ring and send buffer
  ecm_back #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES),
    .RX_FRAMES     (RX_FRAMES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (q_cmd),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

endmodule

/* hdl/ecm_checker.sv */
// port level checks for the frame modem, bound to the top level
`timescale 1ns / 1ps
module ecm_port_checks (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input ecm_pkg::item_t   item,
  input logic             res_valid,
  input ecm_pkg::result_t res
);
  import ecm_pkg::*;

  // reset leaves the queue not full, so busy is low
  a_reset_not_busy: assert property (@(posedge clk) rst |=> !busy)
    else $error("busy after reset");

  // an item without frame data gives one result only
  a_single_is_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.rd_valid |-> res.rd_last)
    else $error("single result not marked last");

  // a popped frame streams without gaps
  a_frame_no_gap: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.rd_valid && !res.rd_last |=> res_valid && res.rd_valid)
    else $error("gap inside frame read");

  // a frame read never sends a line byte
  a_no_tx_on_read: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.rd_valid |-> !res.tx_valid)
    else $error("line byte during frame read");

endmodule

bind echo_checked_crc8_frame_modem_core ecm_port_checks u_ecm_port_checks (.*);
